### rtl/core/lirf_pkg.sv
// Package for the longest increasing run filter: sizes, controller states,
// and the command and status bundles between controller and datapath.
// No dependencies.
package lirf_pkg;

  localparam int MAX_PINS  = 64;
  localparam int POS_WIDTH = 24;

  // Index into the pin stores, a count that can hold MAX_PINS, and a link
  // with one spare code for "no predecessor"
  localparam int IDX_W  = $clog2(MAX_PINS);
  localparam int CNT_W  = $clog2(MAX_PINS + 1);
  localparam int PRED_W = IDX_W + 1;
  localparam logic [PRED_W-1:0] NO_PRED = {PRED_W{1'b1}};

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_WRITE,
    ST_TB_START,
    ST_TB_FIRST,
    ST_TB_NEXT,
    ST_ORD,
    ST_PIN,
    ST_LOAD
  } lirf_state_t;

  typedef struct packed {
    logic load_pin;     // capture the accepted item and start the search
    logic set_ovf;      // store is full: drop the item, flag the list
    logic srch_step;    // one binary search compare
    logic ins_wr;       // write pin, link and tail
    logic tb_start;     // read the longest tail
    logic tb_step;      // record one chain entry, follow its link
    logic tb_from_tail; // chain entry comes from the tail table
    logic out_load;     // move the pin into the output register
    logic clear_list;   // start a new list
  } lirf_cmd_t;

  typedef struct packed {
    logic pin_full;
    logic run_zero;
    logic srch_done;
    logic tb_done;
    logic emit_done;
    logic last_pin;
    logic out_free;
  } lirf_stat_t;

endpackage

### rtl/core/lirf_chan_if.sv
// Valid/ready channel interfaces for the pin input and the kept pin output.
// Depends on lirf_pkg.
interface lirf_pin_if import lirf_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [POS_WIDTH-1:0] backbone_pos;
  logic [POS_WIDTH-1:0] read_pos;
  logic                 is_last;

  modport source (output valid, backbone_pos, read_pos, is_last, input ready);
  modport sink   (input valid, backbone_pos, read_pos, is_last, output ready);
endinterface

interface lirf_kept_if import lirf_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [POS_WIDTH-1:0] kept_backbone_pos;
  logic [POS_WIDTH-1:0] kept_read_pos;
  logic                 last_kept;
  logic                 overflowed;

  modport source (output valid, kept_backbone_pos, kept_read_pos, last_kept, overflowed,
                  input ready);
  modport sink   (input valid, kept_backbone_pos, kept_read_pos, last_kept, overflowed,
                  output ready);
endinterface

### rtl/core/lirf_ram.sv
// Generic simple dual port RAM: one write port, one read port, registered read.
// No dependencies.
module lirf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and register the read data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/lirf_ctrl.sv
// Controller state machine: sequences insert, traceback and emission.
// Depends on lirf_pkg.
module lirf_ctrl import lirf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  lirf_stat_t stat,
  output lirf_cmd_t  cmd
);

  lirf_state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_pin = 1'b1;
          if (stat.pin_full) begin
            cmd.set_ovf = 1'b1;
            state_nxt   = stat.last_pin ? ST_TB_START : ST_IDLE;
          end else if (stat.run_zero) begin
            state_nxt = ST_WRITE;
          end else begin
            state_nxt = ST_SEARCH;
          end
        end
      end
      ST_SEARCH: begin
        cmd.srch_step = 1'b1;
        if (stat.srch_done) begin
          state_nxt = ST_WRITE;
        end
      end
      ST_WRITE: begin
        cmd.ins_wr = 1'b1;
        state_nxt  = stat.last_pin ? ST_TB_START : ST_IDLE;
      end
      ST_TB_START: begin
        if (stat.run_zero) begin
          cmd.clear_list = 1'b1;
          state_nxt      = ST_IDLE;
        end else begin
          cmd.tb_start = 1'b1;
          state_nxt    = ST_TB_FIRST;
        end
      end
      ST_TB_FIRST: begin
        cmd.tb_step      = 1'b1;
        cmd.tb_from_tail = 1'b1;
        state_nxt        = stat.tb_done ? ST_ORD : ST_TB_NEXT;
      end
      ST_TB_NEXT: begin
        cmd.tb_step = 1'b1;
        if (stat.tb_done) begin
          state_nxt = ST_ORD;
        end
      end
      ST_ORD: begin
        // Chain entry read is in flight
        state_nxt = ST_PIN;
      end
      ST_PIN: begin
        // Pin read is in flight
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        // Hold until the output register frees up
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          if (stat.emit_done) begin
            cmd.clear_list = 1'b1;
            state_nxt      = ST_IDLE;
          end else begin
            state_nxt = ST_ORD;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

### rtl/core/lirf_datapath.sv
// Datapath: pin stores, tail tables, predecessor links, chain buffer,
// binary search registers and the output register. Depends on lirf_pkg, lirf_ram.
module lirf_datapath import lirf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lirf_cmd_t            cmd,
  output lirf_stat_t           stat,
  input  logic [POS_WIDTH-1:0] in_backbone_pos,
  input  logic [POS_WIDTH-1:0] in_read_pos,
  input  logic                 in_is_last,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [POS_WIDTH-1:0] out_kept_backbone_pos,
  output logic [POS_WIDTH-1:0] out_kept_read_pos,
  output logic                 out_last_kept,
  output logic                 out_overflowed
);

  // Control state
  logic [CNT_W-1:0]     pin_cnt_r, pin_cnt_nxt;
  logic [CNT_W-1:0]     run_len_r, run_len_nxt;
  logic                 ovf_r, ovf_nxt;
  logic                 out_valid_r, out_valid_nxt;

  // Working registers
  logic [POS_WIDTH-1:0] bb_r, rp_r;
  logic                 last_r;
  logic [CNT_W-1:0]     lo_r, hi_r, mid_r;
  logic [PRED_W-1:0]    pred_r;
  logic [IDX_W-1:0]     pos_r, k_r;
  logic [POS_WIDTH-1:0] obb_r, orp_r;
  logic                 olast_r, oovf_r;

  // RAM read data
  logic [IDX_W-1:0]     tidx_rd, chain_rd;
  logic [POS_WIDTH-1:0] tval_rd, pbb_rd, prp_rd;
  logic [PRED_W-1:0]    pred_rd;

  // Search step
  logic                 cmp_lt;
  logic [CNT_W-1:0]     lo_nxt, hi_nxt, mid_nxt, run_m1;
  logic [CNT_W:0]       mid_sum;
  logic [PRED_W-1:0]    pred_nxt;
  logic [IDX_W-1:0]     tail_raddr, cur;

  assign cmp_lt   = tval_rd < rp_r;
  assign lo_nxt   = cmp_lt ? (mid_r + CNT_W'(1)) : lo_r;
  assign hi_nxt   = cmp_lt ? hi_r : mid_r;
  assign pred_nxt = cmp_lt ? PRED_W'(tidx_rd) : pred_r;
  assign mid_sum  = {1'b0, lo_nxt} + {1'b0, hi_nxt};
  assign mid_nxt  = mid_sum[CNT_W:1];
  assign run_m1   = run_len_r - CNT_W'(1);

  // Pick the tail table read address: longest tail, next probe, or first probe
  always_comb begin
    if (cmd.tb_start) begin
      tail_raddr = run_m1[IDX_W-1:0];
    end else if (cmd.srch_step) begin
      tail_raddr = mid_nxt[IDX_W-1:0];
    end else begin
      tail_raddr = run_len_r[IDX_W:1];
    end
  end

  // Chain entry during traceback
  assign cur = cmd.tb_from_tail ? tidx_rd : pred_rd[IDX_W-1:0];

  lirf_ram #(.WIDTH(POS_WIDTH), .DEPTH(MAX_PINS)) u_pin_bb (
    .clk(clk), .we(cmd.ins_wr), .waddr(pin_cnt_r[IDX_W-1:0]), .wdata(bb_r),
    .raddr(chain_rd), .rdata(pbb_rd)
  );

  lirf_ram #(.WIDTH(POS_WIDTH), .DEPTH(MAX_PINS)) u_pin_rp (
    .clk(clk), .we(cmd.ins_wr), .waddr(pin_cnt_r[IDX_W-1:0]), .wdata(rp_r),
    .raddr(chain_rd), .rdata(prp_rd)
  );

  lirf_ram #(.WIDTH(IDX_W), .DEPTH(MAX_PINS)) u_tail_idx (
    .clk(clk), .we(cmd.ins_wr), .waddr(lo_r[IDX_W-1:0]), .wdata(pin_cnt_r[IDX_W-1:0]),
    .raddr(tail_raddr), .rdata(tidx_rd)
  );

  lirf_ram #(.WIDTH(POS_WIDTH), .DEPTH(MAX_PINS)) u_tail_val (
    .clk(clk), .we(cmd.ins_wr), .waddr(lo_r[IDX_W-1:0]), .wdata(rp_r),
    .raddr(tail_raddr), .rdata(tval_rd)
  );

  lirf_ram #(.WIDTH(PRED_W), .DEPTH(MAX_PINS)) u_pred (
    .clk(clk), .we(cmd.ins_wr), .waddr(pin_cnt_r[IDX_W-1:0]), .wdata(pred_r),
    .raddr(cur), .rdata(pred_rd)
  );

  lirf_ram #(.WIDTH(IDX_W), .DEPTH(MAX_PINS)) u_chain (
    .clk(clk), .we(cmd.tb_step), .waddr(pos_r), .wdata(cur),
    .raddr(k_r), .rdata(chain_rd)
  );

  // Next values of the list counters and the output valid
  always_comb begin
    pin_cnt_nxt   = pin_cnt_r;
    run_len_nxt   = run_len_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r;
    if (cmd.ins_wr) begin
      pin_cnt_nxt = pin_cnt_r + CNT_W'(1);
      if (lo_r == run_len_r) begin
        run_len_nxt = run_len_r + CNT_W'(1);
      end
    end
    if (cmd.set_ovf) begin
      ovf_nxt = 1'b1;
    end
    if (cmd.clear_list) begin
      pin_cnt_nxt = '0;
      run_len_nxt = '0;
      ovf_nxt     = 1'b0;
    end
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pin_cnt_r   <= '0;
      run_len_r   <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pin_cnt_r   <= pin_cnt_nxt;
      run_len_r   <= run_len_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and search registers
  always_ff @(posedge clk) begin
    if (cmd.load_pin) begin
      bb_r   <= in_backbone_pos;
      rp_r   <= in_read_pos;
      last_r <= in_is_last;
      lo_r   <= '0;
      hi_r   <= run_len_r;
      mid_r  <= run_len_r >> 1;
      pred_r <= NO_PRED;
    end
    if (cmd.srch_step) begin
      lo_r   <= lo_nxt;
      hi_r   <= hi_nxt;
      mid_r  <= mid_nxt;
      pred_r <= pred_nxt;
    end
    if (cmd.tb_start) begin
      pos_r <= run_m1[IDX_W-1:0];
      k_r   <= '0;
    end
    if (cmd.tb_step) begin
      pos_r <= pos_r - IDX_W'(1);
    end
    if (cmd.out_load) begin
      obb_r   <= pbb_rd;
      orp_r   <= prp_rd;
      olast_r <= stat.emit_done;
      oovf_r  <= ovf_r;
      k_r     <= k_r + IDX_W'(1);
    end
  end

  // Status to the controller
  assign stat.pin_full  = pin_cnt_r == CNT_W'(MAX_PINS);
  assign stat.run_zero  = run_len_r == '0;
  assign stat.srch_done = lo_nxt >= hi_nxt;
  assign stat.tb_done   = pos_r == '0;
  assign stat.emit_done = CNT_W'(k_r) == run_m1;
  assign stat.last_pin  = cmd.load_pin ? in_is_last : last_r;
  assign stat.out_free  = !out_valid_r || out_ready;

  assign out_valid             = out_valid_r;
  assign out_kept_backbone_pos = obb_r;
  assign out_kept_read_pos     = orp_r;
  assign out_last_kept         = olast_r;
  assign out_overflowed        = oovf_r;

endmodule

### rtl/core/longest_increasing_run_filter.sv
// Longest increasing run filter top level: controller plus datapath.
// Depends on lirf_pkg, lirf_chan_if, lirf_ctrl, lirf_datapath.
//
// Usage: send one pin per item on in_ch (valid/ready), sorted by backbone
// position, with is_last set on the final pin of a list. Each pin is placed
// into a tails table by binary search on read_pos, one probe per cycle from
// a registered-read tail RAM. On the last pin the block follows the
// predecessor links back from the longest tail, then emits the kept pins in
// list order on out_ch, each through a chain read and then a pin read, with
// last_kept marking the final one. A list of one pin comes back unchanged.
// Pins beyond MAX_PINS are dropped and overflowed is set on every result of
// that list.
// in_ch.ready is high only while the controller waits for a pin; it rises as
// the last result enters the output register, so a new list can start while
// that result waits. When the receiver stalls, the output register holds its
// item and emission pauses. Synchronous reset empties the list and the
// output register; store contents are not cleared.
module longest_increasing_run_filter import lirf_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  lirf_pin_if.sink     in_ch,
  lirf_kept_if.source  out_ch
);

  lirf_cmd_t  cmd;
  lirf_stat_t stat;
  logic       in_ready;

  lirf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lirf_datapath u_datapath (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .stat                  (stat),
    .in_backbone_pos       (in_ch.backbone_pos),
    .in_read_pos           (in_ch.read_pos),
    .in_is_last            (in_ch.is_last),
    .out_valid             (out_ch.valid),
    .out_ready             (out_ch.ready),
    .out_kept_backbone_pos (out_ch.kept_backbone_pos),
    .out_kept_read_pos     (out_ch.kept_read_pos),
    .out_last_kept         (out_ch.last_kept),
    .out_overflowed        (out_ch.overflowed)
  );

  assign in_ch.ready = in_ready;

endmodule

### rtl/core/lirf_checker.sv
// Port-level checker for the longest increasing run filter, bound to the top.
// Depends on lirf_pkg and longest_increasing_run_filter.
module lirf_checker import lirf_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 in_is_last,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [POS_WIDTH-1:0] out_kept_backbone_pos,
  input logic [POS_WIDTH-1:0] out_kept_read_pos,
  input logic                 out_last_kept,
  input logic                 out_overflowed
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output item dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_kept_backbone_pos) &&
      $stable(out_kept_read_pos) && $stable(out_last_kept) && $stable(out_overflowed))
    else $error("output payload changed while stalled");

  // A last pin starts a busy stretch
  a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_is_last |=> !in_ready)
    else $error("input accepted right after last pin");

  // No new pin while a list is still being emitted
  a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_kept |-> !in_ready)
    else $error("input ready during emission");

endmodule

bind longest_increasing_run_filter lirf_checker u_lirf_checker (
  .clk                   (clk),
  .rst_n                 (rst_n),
  .in_valid              (in_ch.valid),
  .in_ready              (in_ch.ready),
  .in_is_last            (in_ch.is_last),
  .out_valid             (out_ch.valid),
  .out_ready             (out_ch.ready),
  .out_kept_backbone_pos (out_ch.kept_backbone_pos),
  .out_kept_read_pos     (out_ch.kept_read_pos),
  .out_last_kept         (out_ch.last_kept),
  .out_overflowed        (out_ch.overflowed)
);
